[sv/bfr_pkg.sv]
// Shared constants, types and helpers of the bilinear frame resampler.
package bfr_pkg;

   localparam int MAX_RANGE_BINS  = 1024;
   localparam int MAX_ANGLE_LINES = 256;
   localparam int FRAC_BITS       = 8;

   localparam int ACTION_W      = 1;
   localparam int WR_ANGLE_W    = 8;
   localparam int WR_RANGE_W    = 10;
   localparam int SAMPLE_W      = 8;
   localparam int RANGE_POS_W   = 19;
   localparam int ANGLE_POS_W   = 17;
   localparam int PIXEL_W       = 8;

   localparam int RANGE_REG_W   = 11;
   localparam int ANGLE_REG_W   = 9;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_BINS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_LINES = 1'b1;

   localparam logic [ACTION_W-1:0] ACTION_WRITE = 1'b0;
   localparam logic [ACTION_W-1:0] ACTION_QUERY = 1'b1;

   localparam int COL_W = (MAX_RANGE_BINS > 1) ? $clog2(MAX_RANGE_BINS) : 1;
   localparam int ROW_W = (MAX_ANGLE_LINES > 1) ? $clog2(MAX_ANGLE_LINES) : 1;

   localparam int BCOL_W     = (COL_W > 1) ? COL_W - 1 : 1;
   localparam int BROW_W     = (ROW_W > 1) ? ROW_W - 1 : 1;
   localparam int BANK_AW    = BROW_W + BCOL_W;
   localparam int BANK_DEPTH = 2 ** BANK_AW;
   localparam int NUM_BANKS  = 4;

   localparam int RINT_W = RANGE_POS_W - 1 - FRAC_BITS;
   localparam int AINT_W = ANGLE_POS_W - 1 - FRAC_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                  is_query;
      logic                  wr_ok;
      logic                  zero;
      logic [ROW_W-1:0]      a1;
      logic [ROW_W-1:0]      a2;
      logic [COL_W-1:0]      r1;
      logic [COL_W-1:0]      r2;
      logic [FRAC_BITS-1:0]  fr;
      logic [FRAC_BITS-1:0]  fa;
      logic [SAMPLE_W-1:0]   sample;
   } cmd_type;

   function automatic int unsigned last_index(input int unsigned v, input int unsigned maxv);
      int unsigned res;
      if (v == 0) begin
         res = 0;
      end else if (v > maxv) begin
         res = maxv - 1;
      end else begin
         res = v - 1;
      end
      return res;
   endfunction

endpackage

[sv/bfr_if.sv]
// Handshake channels of the bilinear frame resampler: request, response and register write.
interface bfr_req_if;
   import bfr_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [ACTION_W-1:0]           action;
   logic [WR_ANGLE_W-1:0]         write_angle_line;
   logic [WR_RANGE_W-1:0]         write_range_bin;
   logic [SAMPLE_W-1:0]           write_sample;
   logic signed [RANGE_POS_W-1:0] range_pos;
   logic signed [ANGLE_POS_W-1:0] angle_pos;
   logic                          mask_valid;

   modport source (output valid, output action, output write_angle_line,
                   output write_range_bin, output write_sample, output range_pos,
                   output angle_pos, output mask_valid, input ready);
   modport sink (input valid, input action, input write_angle_line,
                 input write_range_bin, input write_sample, input range_pos,
                 input angle_pos, input mask_valid, output ready);
endinterface

interface bfr_rsp_if;
   import bfr_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface bfr_csr_if;
   import bfr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/bfr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bfr_front.sv]
// Front end: register writes, item decode, clamping of neighbour coordinates.
module bfr_front (
   input  logic             clock,
   input  logic             reset,
   bfr_req_if.sink          req_chan,
   bfr_csr_if.sink          csr_chan,
   output logic             push_valid,
   input  logic             push_ready,
   output bfr_pkg::cmd_type push_cmd
);
   import bfr_pkg::*;

   localparam int RC_W  = ((RINT_W > COL_W) ? RINT_W : COL_W) + 1;
   localparam int AC_W  = ((AINT_W > ROW_W) ? AINT_W : ROW_W) + 1;
   localparam int WRR_W = ((WR_ANGLE_W > ROW_W) ? WR_ANGLE_W : ROW_W) + 1;
   localparam int WRC_W = ((WR_RANGE_W > COL_W) ? WR_RANGE_W : COL_W) + 1;

   logic [COL_W-1:0]  cols_last_ff, cols_last_in;
   logic [ROW_W-1:0]  rows_last_ff, rows_last_in;
   logic [RINT_W-1:0] r_int;
   logic [AINT_W-1:0] a_int;
   logic              r_clamp, a_clamp;
   logic [COL_W-1:0]  qr1, qr2;
   logic [ROW_W-1:0]  qa1, qa2;
   logic [WRR_W-1:0]  wr_row;
   logic [WRC_W-1:0]  wr_col;
   logic              wr_in_bounds;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cols_last_in = cols_last_ff;
      rows_last_in = rows_last_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_RANGE_BINS: begin
               cols_last_in = COL_W'(last_index(32'(csr_chan.data[RANGE_REG_W-1:0]),
                                                MAX_RANGE_BINS));
            end
            CSR_ANGLE_LINES: begin
               rows_last_in = ROW_W'(last_index(32'(csr_chan.data[ANGLE_REG_W-1:0]),
                                                MAX_ANGLE_LINES));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_last_ff <= COL_W'(MAX_RANGE_BINS - 1);
         rows_last_ff <= ROW_W'(MAX_ANGLE_LINES - 1);
      end else begin
         cols_last_ff <= cols_last_in;
         rows_last_ff <= rows_last_in;
      end
   end

   assign r_int   = req_chan.range_pos[RANGE_POS_W-2:FRAC_BITS];
   assign a_int   = req_chan.angle_pos[ANGLE_POS_W-2:FRAC_BITS];
   assign r_clamp = RC_W'(r_int) >= RC_W'(cols_last_ff);
   assign a_clamp = AC_W'(a_int) >= AC_W'(rows_last_ff);
   assign qr1     = r_clamp ? cols_last_ff : COL_W'(r_int);
   assign qa1     = a_clamp ? rows_last_ff : ROW_W'(a_int);
   assign qr2     = r_clamp ? qr1 : COL_W'(qr1 + 1'b1);
   assign qa2     = a_clamp ? qa1 : ROW_W'(qa1 + 1'b1);

   assign wr_row       = WRR_W'(req_chan.write_angle_line);
   assign wr_col       = WRC_W'(req_chan.write_range_bin);
   assign wr_in_bounds = (wr_row < WRR_W'(MAX_ANGLE_LINES)) && (wr_col < WRC_W'(MAX_RANGE_BINS));

   always_comb begin
      push_cmd.is_query = (req_chan.action == ACTION_QUERY);
      push_cmd.wr_ok    = wr_in_bounds;
      push_cmd.zero     = !req_chan.mask_valid || req_chan.range_pos[RANGE_POS_W-1]
                          || req_chan.angle_pos[ANGLE_POS_W-1];
      push_cmd.fr       = req_chan.range_pos[FRAC_BITS-1:0];
      push_cmd.fa       = req_chan.angle_pos[FRAC_BITS-1:0];
      push_cmd.sample   = req_chan.write_sample;
      if (req_chan.action == ACTION_QUERY) begin
         push_cmd.a1 = qa1;
         push_cmd.a2 = qa2;
         push_cmd.r1 = qr1;
         push_cmd.r2 = qr2;
      end else begin
         push_cmd.a1 = wr_row[ROW_W-1:0];
         push_cmd.a2 = wr_row[ROW_W-1:0];
         push_cmd.r1 = wr_col[COL_W-1:0];
         push_cmd.r2 = wr_col[COL_W-1:0];
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

[sv/bfr_queue.sv]
// Short command queue between the front end and the blending pipeline.
module bfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bfr_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output bfr_pkg::cmd_type pop_cmd
);
   import bfr_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/bfr_back.sv]
// Back end: parity-banked frame store, two blend stages and the output register.
module bfr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  bfr_pkg::cmd_type pop_cmd,
   bfr_rsp_if.source        rsp_chan
);
   import bfr_pkg::*;

   localparam int LOV_W = SAMPLE_W + FRAC_BITS;
   localparam int LO_W  = LOV_W + 1;
   localparam int ACC_W = SAMPLE_W + 2 * FRAC_BITS + 2;

   logic                 advance, popped;
   logic [SAMPLE_W-1:0]  bank_rd_data [NUM_BANKS];

   logic                 s1_valid_ff;
   logic                 s1_zero_ff;
   logic                 s1_pa1_ff, s1_pa2_ff, s1_pr1_ff, s1_pr2_ff;
   logic [FRAC_BITS-1:0] s1_fr_ff, s1_fa_ff;

   logic [SAMPLE_W-1:0]  q11, q12, q21, q22;
   logic signed [LO_W-1:0] d_lo, d_hi, fr_ext, prod_lo, prod_hi, sum_lo, sum_hi;

   logic                 s2_valid_ff;
   logic                 s2_zero_ff;
   logic [FRAC_BITS-1:0] s2_fa_ff;
   logic [LOV_W-1:0]     s2_lo_ff, s2_hi_ff;

   logic signed [ACC_W-1:0] d_acc, fa_ext, prod_acc, acc;
   logic [PIXEL_W-1:0]      pixel;

   logic                 rsp_valid_ff;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;

   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = advance;
   assign popped    = pop_valid && advance;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam logic BP = 1'((b >> 1) & 1);
      localparam logic BQ = 1'(b & 1);
      logic [ROW_W-1:0]   row_sel;
      logic [COL_W-1:0]   col_sel;
      logic [BANK_AW-1:0] addr;
      logic               wr_en;

      assign row_sel = (pop_cmd.a1[0] == BP) ? pop_cmd.a1 : pop_cmd.a2;
      assign col_sel = (pop_cmd.r1[0] == BQ) ? pop_cmd.r1 : pop_cmd.r2;
      assign addr    = {BROW_W'(row_sel >> 1), BCOL_W'(col_sel >> 1)};
      assign wr_en   = popped && !pop_cmd.is_query && pop_cmd.wr_ok
                       && (pop_cmd.a1[0] == BP) && (pop_cmd.r1[0] == BQ);

      bfr_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (addr),
         .wr_data (pop_cmd.sample),
         .rd_en   (advance),
         .rd_addr (addr),
         .rd_data (bank_rd_data[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= popped && pop_cmd.is_query;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_zero_ff <= pop_cmd.zero;
         s1_pa1_ff  <= pop_cmd.a1[0];
         s1_pa2_ff  <= pop_cmd.a2[0];
         s1_pr1_ff  <= pop_cmd.r1[0];
         s1_pr2_ff  <= pop_cmd.r2[0];
         s1_fr_ff   <= pop_cmd.fr;
         s1_fa_ff   <= pop_cmd.fa;
      end
   end

   assign q11 = bank_rd_data[{s1_pa1_ff, s1_pr1_ff}];
   assign q12 = bank_rd_data[{s1_pa1_ff, s1_pr2_ff}];
   assign q21 = bank_rd_data[{s1_pa2_ff, s1_pr1_ff}];
   assign q22 = bank_rd_data[{s1_pa2_ff, s1_pr2_ff}];

   assign d_lo    = LO_W'($signed({1'b0, q12})) - LO_W'($signed({1'b0, q11}));
   assign d_hi    = LO_W'($signed({1'b0, q22})) - LO_W'($signed({1'b0, q21}));
   assign fr_ext  = LO_W'($signed({1'b0, s1_fr_ff}));
   assign prod_lo = d_lo * fr_ext;
   assign prod_hi = d_hi * fr_ext;
   assign sum_lo  = $signed({1'b0, q11, {FRAC_BITS{1'b0}}}) + prod_lo;
   assign sum_hi  = $signed({1'b0, q21, {FRAC_BITS{1'b0}}}) + prod_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_zero_ff <= s1_zero_ff;
         s2_fa_ff   <= s1_fa_ff;
         s2_lo_ff   <= sum_lo[LOV_W-1:0];
         s2_hi_ff   <= sum_hi[LOV_W-1:0];
      end
   end

   assign d_acc    = ACC_W'($signed({1'b0, s2_hi_ff})) - ACC_W'($signed({1'b0, s2_lo_ff}));
   assign fa_ext   = ACC_W'($signed({1'b0, s2_fa_ff}));
   assign prod_acc = d_acc * fa_ext;
   assign acc      = $signed({2'b00, s2_lo_ff, {FRAC_BITS{1'b0}}}) + prod_acc
                     + ACC_W'($signed({1'b0, 1'b1, {(2 * FRAC_BITS - 1){1'b0}}}));
   assign pixel    = acc[2 * FRAC_BITS + PIXEL_W - 1:2 * FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= s2_zero_ff ? '0 : pixel;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_value = rsp_pixel_ff;

endmodule

[sv/bilinear_frame_resampler_unit.sv]
// Top level of the bilinear frame resampler: front end, command queue and blend pipeline.
//
//   channel    dir  handshake      carries
//   req_chan   in   valid/ready    sample write or pixel query
//   rsp_chan   out  valid/ready    one pixel per query, nothing per write
//   csr_chan   in   valid/ready    range_bins_in_use, angle_lines_in_use
//
// One item per cycle sustained while rsp_chan is not stalled: the frame sits in four RAM
// banks split by row and column parity, so the four neighbours of a query are read together.
// A query passes the bank read, stage-two and output registers; writes give no result.
// Reset clears control only; the frame holds nothing defined until written.
// A stalled response freezes the blend pipeline; the four-entry queue absorbs
// requests and req_chan.ready drops only when it is full.
module bilinear_frame_resampler_unit (
   input  logic      clock,
   input  logic      reset,
   bfr_req_if.sink   req_chan,
   bfr_rsp_if.source rsp_chan,
   bfr_csr_if.sink   csr_chan
);
   import bfr_pkg::*;

   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   bfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   bfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   bfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

[tb/bfr_resample_check_pkg.sv]
// Request record and pixel scoreboard used by the bilinear frame resampler testbench.
package bfr_resample_check_pkg;
   import bfr_pkg::*;

   localparam int FRAME_CELLS = MAX_ANGLE_LINES * MAX_RANGE_BINS;
   localparam longint unsigned WEIGHT_ONE = 64'd1 << FRAC_BITS;
   localparam longint unsigned ROUND_HALF = 64'd1 << (2 * FRAC_BITS - 1);

   typedef struct {
      logic [ACTION_W-1:0]           action;
      logic [WR_ANGLE_W-1:0]         write_angle_line;
      logic [WR_RANGE_W-1:0]         write_range_bin;
      logic [SAMPLE_W-1:0]           write_sample;
      logic signed [RANGE_POS_W-1:0] range_pos;
      logic signed [ANGLE_POS_W-1:0] angle_pos;
      logic                          mask_valid;
   } request_type;

   class pixel_scoreboard;
      bit [SAMPLE_W-1:0]  frame [FRAME_CELLS];
      int unsigned        range_bins_reg;
      int unsigned        angle_lines_reg;
      logic [PIXEL_W-1:0] expected_pixels [$];
      int unsigned        writes_seen;
      int unsigned        pixels_checked;
      int unsigned        pixels_lit;
      int unsigned        errors;

      function new();
         range_bins_reg  = MAX_RANGE_BINS;
         angle_lines_reg = MAX_ANGLE_LINES;
      endfunction

      static function int unsigned clamp_count(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function int unsigned used_cols();
         return clamp_count(range_bins_reg, MAX_RANGE_BINS);
      endfunction

      function int unsigned used_rows();
         return clamp_count(angle_lines_reg, MAX_ANGLE_LINES);
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_RANGE_BINS) begin
            range_bins_reg = value[RANGE_REG_W-1:0];
         end else begin
            angle_lines_reg = value[ANGLE_REG_W-1:0];
         end
      endfunction

      // neighbour rows and columns of a non-negative position, clamped to the loaded frame
      function void locate(input logic [RANGE_POS_W-1:0] rp, input logic [ANGLE_POS_W-1:0] ap,
                           output int unsigned row_lo, output int unsigned row_hi,
                           output int unsigned col_lo, output int unsigned col_hi);
         int unsigned cols;
         int unsigned rows;
         cols   = used_cols();
         rows   = used_rows();
         col_lo = rp[RANGE_POS_W-2:FRAC_BITS];
         row_lo = ap[ANGLE_POS_W-2:FRAC_BITS];
         if (col_lo >= cols - 1) begin
            col_lo = cols - 1;
            col_hi = col_lo;
         end else begin
            col_hi = col_lo + 1;
         end
         if (row_lo >= rows - 1) begin
            row_lo = rows - 1;
            row_hi = row_lo;
         end else begin
            row_hi = row_lo + 1;
         end
      endfunction

      function logic [PIXEL_W-1:0] blend(request_type q);
         int unsigned       rl, rh, cl, ch;
         longint unsigned   fr, fa, near_row, far_row, acc;
         if (!q.mask_valid || q.range_pos[RANGE_POS_W-1] || q.angle_pos[ANGLE_POS_W-1]) begin
            return '0;
         end
         locate(q.range_pos, q.angle_pos, rl, rh, cl, ch);
         fr       = q.range_pos[FRAC_BITS-1:0];
         fa       = q.angle_pos[FRAC_BITS-1:0];
         near_row = (WEIGHT_ONE - fr) * frame[rl * MAX_RANGE_BINS + cl]
                    + fr * frame[rl * MAX_RANGE_BINS + ch];
         far_row  = (WEIGHT_ONE - fr) * frame[rh * MAX_RANGE_BINS + cl]
                    + fr * frame[rh * MAX_RANGE_BINS + ch];
         acc      = (WEIGHT_ONE - fa) * near_row + fa * far_row + ROUND_HALF;
         return PIXEL_W'(acc >> (2 * FRAC_BITS));
      endfunction

      function void note_request(request_type q);
         if (q.action == ACTION_WRITE) begin
            frame[int'(q.write_angle_line) * MAX_RANGE_BINS + int'(q.write_range_bin)] =
               q.write_sample;
            writes_seen++;
         end else begin
            expected_pixels.insert(expected_pixels.size(), blend(q));
         end
      endfunction

      function void check_pixel(logic [PIXEL_W-1:0] got);
         logic [PIXEL_W-1:0] want;
         if (expected_pixels.size() == 0) begin
            $error("pixel_value: expected none, actual %0d", got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (want != 0) pixels_lit++;
         if (got !== want) begin
            $error("pixel_value: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

endpackage

[tb/tb_bilinear_frame_resampler_unit.sv]
// Testbench top for the bilinear frame resampler: drives writes, queries and frame sizes.
module tb_bilinear_frame_resampler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bfr_pkg::*;
   import bfr_resample_check_pkg::*;

   localparam int NUM_PHASES        = 9;
   localparam int ITEMS_PER_PHASE   = 45;
   localparam int PIPE_DRAIN_CYCLES = 12;
   localparam int RSP_HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT       = 2000;
   localparam int RANGE_TOP         = 2 ** (RANGE_POS_W - 1) - 1;
   localparam int ANGLE_TOP         = 2 ** (ANGLE_POS_W - 1) - 1;

   localparam logic [CSR_DATA_W-1:0] PHASE_COLS [NUM_PHASES] =
      '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd2, 11'd5, 11'd1, 11'd1024, 11'd3};
   localparam logic [CSR_DATA_W-1:0] PHASE_ROWS [NUM_PHASES] =
      '{11'd0, 11'd1, 11'd2047, 11'd256, 11'd2, 11'd3, 11'd1, 11'd1, 11'd9};

   logic clock;
   logic reset;

   bfr_req_if req_bus ();
   bfr_rsp_if rsp_bus ();
   bfr_csr_if csr_bus ();

   bilinear_frame_resampler_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pixel_scoreboard pixels = new();

   bit          sample_loaded [FRAME_CELLS];
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          rsp_hold_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic request_type random_fields();
      request_type it;
      it.action           = ACTION_QUERY;
      it.write_angle_line = WR_ANGLE_W'($urandom);
      it.write_range_bin  = WR_RANGE_W'($urandom);
      it.write_sample     = SAMPLE_W'($urandom);
      it.range_pos        = RANGE_POS_W'($urandom);
      it.angle_pos        = ANGLE_POS_W'($urandom);
      it.mask_valid       = 1'($urandom);
      return it;
   endfunction

   function automatic int pick_position(int unsigned span, int top);
      int unsigned k;
      int unsigned whole;
      k = $urandom_range(99, 0);
      if (k < 8) return -int'($urandom_range(256, 1));
      if (k < 18) return int'($urandom_range(top, 0));
      if (k < 30) begin
         whole = span - 1 - ((span > 1) ? $urandom_range(1, 0) : 0);
      end else begin
         whole = $urandom_range(span - 1, 0);
      end
      return int'((whole << FRAC_BITS) | $urandom_range((1 << FRAC_BITS) - 1, 0));
   endfunction

   task automatic send_request(input request_type it);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.action           <= it.action;
      req_bus.write_angle_line <= it.write_angle_line;
      req_bus.write_range_bin  <= it.write_range_bin;
      req_bus.write_sample     <= it.write_sample;
      req_bus.range_pos        <= it.range_pos;
      req_bus.angle_pos        <= it.angle_pos;
      req_bus.mask_valid       <= it.mask_valid;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_sample(input int unsigned row, input int unsigned col,
                              input logic [SAMPLE_W-1:0] value);
      request_type it;
      it                  = random_fields();
      it.action           = ACTION_WRITE;
      it.write_angle_line = WR_ANGLE_W'(row);
      it.write_range_bin  = WR_RANGE_W'(col);
      it.write_sample     = value;
      sample_loaded[row * MAX_RANGE_BINS + col] = 1'b1;
      send_request(it);
   endtask

   task automatic fill_cell(input int unsigned row, input int unsigned col);
      if (!sample_loaded[row * MAX_RANGE_BINS + col]) begin
         send_sample(row, col, SAMPLE_W'($urandom_range(255, 0)));
      end
   endtask

   // load any neighbour still unwritten before the query reads it
   task automatic issue_query(input logic signed [RANGE_POS_W-1:0] rp,
                              input logic signed [ANGLE_POS_W-1:0] ap,
                              input logic mask);
      request_type it;
      int unsigned rl, rh, cl, ch;
      if (mask && !rp[RANGE_POS_W-1] && !ap[ANGLE_POS_W-1]) begin
         pixels.locate(rp, ap, rl, rh, cl, ch);
         fill_cell(rl, cl);
         fill_cell(rl, ch);
         fill_cell(rh, cl);
         fill_cell(rh, ch);
      end
      it            = random_fields();
      it.range_pos  = rp;
      it.angle_pos  = ap;
      it.mask_valid = mask;
      send_request(it);
   endtask

   task automatic random_step();
      int unsigned k;
      int unsigned cols;
      int unsigned rows;
      k    = $urandom_range(99, 0);
      cols = pixels.used_cols();
      rows = pixels.used_rows();
      if (k < 28) begin
         send_sample($urandom_range(rows - 1, 0), $urandom_range(cols - 1, 0),
                     SAMPLE_W'($urandom_range(255, 0)));
      end else if (k < 35) begin
         send_sample($urandom_range(MAX_ANGLE_LINES - 1, 0),
                     $urandom_range(MAX_RANGE_BINS - 1, 0), SAMPLE_W'($urandom_range(255, 0)));
      end else begin
         issue_query(RANGE_POS_W'(pick_position(cols, RANGE_TOP)),
                     ANGLE_POS_W'(pick_position(rows, ANGLE_TOP)),
                     $urandom_range(99, 0) >= 10);
      end
   endtask

   task automatic wait_for_pixels();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pixels.pending() != 0);
   endtask

   task automatic settle_pipeline();
      wait_for_pixels();
      repeat (PIPE_DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] cols, input logic [CSR_DATA_W-1:0] rows);
      for (int i = 0; i < 2; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= (i == 0) ? CSR_RANGE_BINS : CSR_ANGLE_LINES;
         csr_bus.data  <= (i == 0) ? cols : rows;
         do @(posedge clock); while (!csr_bus.ready);
         pixels.set_register(csr_bus.index, csr_bus.data);
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      request_type seen;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.action           = req_bus.action;
         seen.write_angle_line = req_bus.write_angle_line;
         seen.write_range_bin  = req_bus.write_range_bin;
         seen.write_sample     = req_bus.write_sample;
         seen.range_pos        = req_bus.range_pos;
         seen.angle_pos        = req_bus.angle_pos;
         seen.mask_valid       = req_bus.mask_valid;
         pixels.note_request(seen);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         pixels.check_pixel(rsp_bus.pixel_value);
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_bilinear_frame_resampler_unit: errors");
      $finish;
   end

   initial begin
      int unsigned              settings;
      logic [CSR_DATA_W-1:0]    cols;
      logic [CSR_DATA_W-1:0]    rows;
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.action           <= ACTION_WRITE;
      req_bus.write_angle_line <= '0;
      req_bus.write_range_bin  <= '0;
      req_bus.write_sample     <= '0;
      req_bus.range_pos        <= '0;
      req_bus.angle_pos        <= '0;
      req_bus.mask_valid       <= 1'b0;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= CSR_RANGE_BINS;
      csr_bus.data             <= '0;
      rsp_hold_req   = 1'b0;
      send_idle_pct  = 31;
      recv_stall_pct = 86;
      settings       = 1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_sample(0, 0, 8'd0);
      send_sample(0, 1, 8'd255);
      send_sample(1, 0, 8'd0);
      send_sample(1, 1, 8'd255);
      send_sample(MAX_ANGLE_LINES - 1, MAX_RANGE_BINS - 1, 8'd255);
      issue_query(RANGE_POS_W'(0), ANGLE_POS_W'(0), 1'b1);
      issue_query(RANGE_POS_W'(128), ANGLE_POS_W'(0), 1'b1);
      issue_query(RANGE_POS_W'(255), ANGLE_POS_W'(255), 1'b1);
      issue_query(RANGE_POS_W'(RANGE_TOP), ANGLE_POS_W'(ANGLE_TOP), 1'b1);
      issue_query(RANGE_POS_W'(1022 * 256 + 200), ANGLE_POS_W'(255 * 256 + 77), 1'b1);
      issue_query(RANGE_POS_W'(-256), ANGLE_POS_W'(0), 1'b1);
      issue_query(RANGE_POS_W'(0), ANGLE_POS_W'(-1), 1'b1);
      issue_query(RANGE_POS_W'(-1), ANGLE_POS_W'(-256), 1'b1);
      issue_query(RANGE_POS_W'(128), ANGLE_POS_W'(128), 1'b0);
      issue_query(RANGE_POS_W'(RANGE_TOP), ANGLE_POS_W'(ANGLE_TOP), 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 3) begin
            send_idle_pct  = 86;
            recv_stall_pct = 31;
         end else if (p == 6) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         cols = PHASE_COLS[p];
         rows = PHASE_ROWS[p];
         if (p == 6) begin
            cols = CSR_DATA_W'($urandom_range(MAX_RANGE_BINS, 1));
            rows = CSR_DATA_W'($urandom_range(MAX_ANGLE_LINES, 1));
         end
         settle_pipeline();
         configure(cols, rows);
         settings++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 1 && n == ITEMS_PER_PHASE / 2) wait_for_pixels();
            if (p == 7 && n == 5) rsp_hold_req = 1'b1;
            random_step();
         end
      end
      settle_pipeline();

      $display("covered %0d sample writes and %0d checked pixels (%0d non-zero)",
               pixels.writes_seen, pixels.pixels_checked, pixels.pixels_lit);
      $display("over %0d frame size settings, with and without idling on both sides", settings);
      if (pixels.errors == 0) begin
         $display("tb_bilinear_frame_resampler_unit: clean");
      end else begin
         $display("tb_bilinear_frame_resampler_unit: errors");
      end
      $finish;
   end

endmodule

[bilinear_frame_resampler_unit.f]
sv/bfr_pkg.sv
sv/bfr_if.sv
sv/bfr_ram.sv
sv/bfr_front.sv
sv/bfr_queue.sv
sv/bfr_back.sv
sv/bilinear_frame_resampler_unit.sv
tb/bfr_resample_check_pkg.sv
tb/tb_bilinear_frame_resampler_unit.sv
